// File: rtl/http_chunked_body_decoder_assert.svh
// Assertion macros shared by the chunked body decoder modules.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is low.
`define HCBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds through reset.
`define HCBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HCBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define HCBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/hcbd_pkg.sv
// Types, constants and helper functions for the chunked body decoder.
package hcbd_pkg;

    // Default number of hex digits allowed in one size line.
    localparam int SIZE_DIGITS_DEF = 8;

    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [1:0] TRAILER_LEN = 2'd2;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_LF,
        PH_PAYLOAD,
        PH_TRAILER,
        PH_ENDED
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_END,
        KIND_BAD
    } t_kind;

    // One result from the parser: valid flag, payload byte and its kind.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        t_kind      kind;
    } t_result;

    // Decode an ASCII hex digit: bit 4 flags a digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                v = {1'b1, c[3:0]};
            end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
                v = {1'b1, c[3:0] + 4'd9};
            end else begin
                v = 5'd0;
            end
            return v;
        end
    endfunction

endpackage

// File: rtl/http_chunked_body_decoder.sv
// Top level of the HTTP chunked transfer body decoder.
// Takes one byte of a chunked body per input transaction and returns the bare payload bytes,
// plus at most one end-of-body or malformed-size marker per body. Sustained rate is one byte
// per clock while the output is not stalled; a byte's result passes through the input register,
// then the phase and size-counter update into the result register. Bytes that yield no result
// (size digits, CR LF, trailer bytes, bytes after the end) are consumed without occupying the
// output. Size lines longer than SIZE_DIGITS hex digits are flagged as malformed; there is no
// clearing pass after reset.
`include "http_chunked_body_decoder_assert.svh"

module http_chunked_body_decoder #(
    parameter int SIZE_DIGITS = hcbd_pkg::SIZE_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_body_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_result_kind
);

    logic              r_s1_valid;
    logic [7:0]        r_s1_byte;
    logic              r_s1_start;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    hcbd_pkg::t_kind   r_out_kind;

    logic              out_free;
    logic              s1_fire;
    logic              in_accept;
    hcbd_pkg::t_result res;

    // Stage 1 moves on whenever the result register can take a transaction
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    hcbd_parse #(
        .SIZE_DIGITS(SIZE_DIGITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_byte  (r_s1_byte),
        .i_start (r_s1_start),
        .o_res   (res)
    );

    // Input register: hold while stalled, refill when consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte  <= i_in_byte;
            r_s1_start <= i_body_start;
        end
    end

    // Result register: load a fresh result or drain the taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && res.valid) begin
            r_out_byte <= res.data;
            r_out_kind <= res.kind;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_result_kind = r_out_kind;

    `HCBD_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid, "output valid straight after reset")
    `HCBD_ASSERT(a_stall_needs_item, i_clk, i_rst_n, o_in_stall |-> (r_s1_valid && r_out_valid), "input stalled with nothing blocking")
    `HCBD_ASSERT(a_s1_held, i_clk, i_rst_n, (r_s1_valid && o_in_stall) |=> (r_s1_valid && r_s1_byte == $past(r_s1_byte)), "stage 1 transaction lost while blocked")
    `HCBD_ASSERT(a_marker_zero, i_clk, i_rst_n, (o_out_valid && r_out_kind != hcbd_pkg::KIND_DATA) |-> (o_out_byte == 8'd0), "marker result carries a non-zero byte")

endmodule

// File: rtl/hcbd_parse.sv
// Chunk parser: phase machine, size counter and per-byte result.
`include "http_chunked_body_decoder_assert.svh"

module hcbd_parse #(
    parameter int SIZE_DIGITS = hcbd_pkg::SIZE_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  logic              i_start,
    output hcbd_pkg::t_result o_res
);

    localparam int CW  = 4 * SIZE_DIGITS;
    localparam int DCW = $clog2(SIZE_DIGITS + 1);

    hcbd_pkg::t_phase r_phase,   n_phase;
    logic [CW-1:0]    r_chunk,   n_chunk;
    logic [DCW-1:0]   r_digits,  n_digits;
    logic [1:0]       r_trailer, n_trailer;

    hcbd_pkg::t_phase c_phase;
    logic [CW-1:0]    c_chunk;
    logic [DCW-1:0]   c_digits;
    logic [1:0]       c_trailer;
    logic [4:0]       hv;

    // Restart from the reset state when the transaction opens a new body
    assign c_phase   = i_start ? hcbd_pkg::PH_SIZE : r_phase;
    assign c_chunk   = i_start ? '0 : r_chunk;
    assign c_digits  = i_start ? '0 : r_digits;
    assign c_trailer = i_start ? 2'd0 : r_trailer;
    assign hv        = hcbd_pkg::hex_value(i_byte);

    // Next state and result for the byte at hand
    always_comb begin
        n_phase   = c_phase;
        n_chunk   = c_chunk;
        n_digits  = c_digits;
        n_trailer = c_trailer;
        o_res     = '{valid: 1'b0, data: 8'd0, kind: hcbd_pkg::KIND_DATA};
        case (c_phase)
            hcbd_pkg::PH_SIZE: begin
                if (hv[4]) begin
                    if (c_digits == DCW'(SIZE_DIGITS)) begin
                        n_phase = hcbd_pkg::PH_ENDED;
                        o_res   = '{valid: 1'b1, data: 8'd0, kind: hcbd_pkg::KIND_BAD};
                    end else begin
                        n_chunk  = (c_chunk << 4) | CW'(hv[3:0]);
                        n_digits = c_digits + DCW'(1);
                    end
                end else if (i_byte == hcbd_pkg::BYTE_CR) begin
                    n_phase = hcbd_pkg::PH_LF;
                end else begin
                    n_phase = hcbd_pkg::PH_ENDED;
                    o_res   = '{valid: 1'b1, data: 8'd0, kind: hcbd_pkg::KIND_BAD};
                end
            end
            hcbd_pkg::PH_LF: begin
                if (i_byte != hcbd_pkg::BYTE_LF) begin
                    n_phase = hcbd_pkg::PH_ENDED;
                    o_res   = '{valid: 1'b1, data: 8'd0, kind: hcbd_pkg::KIND_BAD};
                end else if (c_digits == '0 || c_chunk == '0) begin
                    n_phase = hcbd_pkg::PH_ENDED;
                    o_res   = '{valid: 1'b1, data: 8'd0, kind: hcbd_pkg::KIND_END};
                end else begin
                    n_phase = hcbd_pkg::PH_PAYLOAD;
                end
            end
            hcbd_pkg::PH_PAYLOAD: begin
                n_chunk = c_chunk - CW'(1);
                if (n_chunk == '0) begin
                    n_phase   = hcbd_pkg::PH_TRAILER;
                    n_trailer = hcbd_pkg::TRAILER_LEN;
                end
                o_res = '{valid: 1'b1, data: i_byte, kind: hcbd_pkg::KIND_DATA};
            end
            hcbd_pkg::PH_TRAILER: begin
                if (c_trailer != 2'd0) begin
                    n_trailer = c_trailer - 2'd1;
                end
                if (n_trailer == 2'd0) begin
                    n_phase  = hcbd_pkg::PH_SIZE;
                    n_chunk  = '0;
                    n_digits = '0;
                end
            end
            default: begin
                // Ended: drop bytes until the next body start
            end
        endcase
    end

    // Advance parser state once per consumed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= hcbd_pkg::PH_SIZE;
            r_chunk   <= '0;
            r_digits  <= '0;
            r_trailer <= 2'd0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_chunk   <= n_chunk;
            r_digits  <= n_digits;
            r_trailer <= n_trailer;
        end
    end

    `HCBD_ASSERT(a_digits_bound, i_clk, i_rst_n, r_digits <= DCW'(SIZE_DIGITS), "size digit count beyond limit")
    `HCBD_ASSERT(a_ended_silent, i_clk, i_rst_n, (r_phase == hcbd_pkg::PH_ENDED && !i_start) |-> !o_res.valid, "result produced after end of body")
    `HCBD_ASSERT(a_payload_nonzero, i_clk, i_rst_n, (r_phase == hcbd_pkg::PH_PAYLOAD) |-> (r_chunk != '0), "payload phase with no bytes left")

endmodule

// File: tb/hcbd_checker.sv
// Checker for the chunked body decoder: predicts each result and compares it with the output.
module hcbd_checker #(
    parameter int SIZE_DIGITS = hcbd_pkg::SIZE_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_body_start,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic [1:0] i_result_kind,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int SIZE_W = 4 * SIZE_DIGITS;

    typedef struct packed {
        logic [7:0]      data;
        hcbd_pkg::t_kind kind;
    } t_decoded;

    // Parser state as the decoder should hold it
    hcbd_pkg::t_phase  phase_q;
    logic [SIZE_W-1:0] size_left;
    int                digits_seen;
    logic [1:0]        skip_left;

    t_decoded decoded_due[$];
    int       fail_tally = 0;

    // Return the value of an ASCII hex digit, or -1 for any other byte
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    task automatic clear_parser();
        phase_q     = hcbd_pkg::PH_SIZE;
        size_left   = '0;
        digits_seen = 0;
        skip_left   = '0;
    endtask

    task automatic owe(input logic [7:0] d, input hcbd_pkg::t_kind k);
        t_decoded item;
        item.data   = d;
        item.kind   = k;
        decoded_due = {decoded_due, item};
    endtask

    task automatic note_failure();
        fail_tally++;
    endtask

    // Advance the parser by one byte and queue the result it owes, if any
    task automatic decode_byte(input logic [7:0] b, input logic start);
        int nib;
        nib = nibble_of(b);
        if (start) begin
            clear_parser();
        end
        case (phase_q)
            hcbd_pkg::PH_SIZE: begin
                if (nib >= 0) begin
                    if (digits_seen >= SIZE_DIGITS) begin
                        phase_q = hcbd_pkg::PH_ENDED;
                        owe(8'h00, hcbd_pkg::KIND_BAD);
                    end else begin
                        size_left = (size_left << 4) | SIZE_W'(nib);
                        digits_seen++;
                    end
                end else if (b == hcbd_pkg::BYTE_CR) begin
                    phase_q = hcbd_pkg::PH_LF;
                end else begin
                    phase_q = hcbd_pkg::PH_ENDED;
                    owe(8'h00, hcbd_pkg::KIND_BAD);
                end
            end
            hcbd_pkg::PH_LF: begin
                if (b != hcbd_pkg::BYTE_LF) begin
                    phase_q = hcbd_pkg::PH_ENDED;
                    owe(8'h00, hcbd_pkg::KIND_BAD);
                end else if (digits_seen == 0 || size_left == '0) begin
                    phase_q = hcbd_pkg::PH_ENDED;
                    owe(8'h00, hcbd_pkg::KIND_END);
                end else begin
                    phase_q = hcbd_pkg::PH_PAYLOAD;
                end
            end
            hcbd_pkg::PH_PAYLOAD: begin
                size_left = size_left - 1'b1;
                if (size_left == '0) begin
                    phase_q   = hcbd_pkg::PH_TRAILER;
                    skip_left = hcbd_pkg::TRAILER_LEN;
                end
                owe(b, hcbd_pkg::KIND_DATA);
            end
            hcbd_pkg::PH_TRAILER: begin
                if (skip_left != '0) begin
                    skip_left = skip_left - 1'b1;
                end
                if (skip_left == '0) begin
                    phase_q     = hcbd_pkg::PH_SIZE;
                    size_left   = '0;
                    digits_seen = 0;
                end
            end
            default: begin
                // hold silent until the next body start
            end
        endcase
    endtask

    // Compare one output transaction with the oldest owed result
    task automatic check_result();
        t_decoded want;
        if (decoded_due.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual byte %02h kind %0d",
                     $time, i_out_byte, i_result_kind);
            note_failure();
        end else begin
            want = decoded_due.pop_front();
            if (i_out_byte !== want.data) begin
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, want.data, i_out_byte);
                note_failure();
            end
            if (i_result_kind !== want.kind) begin
                $display("%0t: result_kind mismatch: expected %0d (%s), actual %0d",
                         $time, want.kind, want.kind.name(), i_result_kind);
                note_failure();
            end
        end
    endtask

    // Check the output first, then predict from the input accepted at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            decoded_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_in_byte, i_body_start);
            end
        end
        o_pending    <= decoded_due.size();
        o_fail_count <= fail_tally;
    end

endmodule

// File: tb/tb_top.sv
// Top of the chunked body decoder testbench: clock, reset, byte stimulus and verdict.
module tb_top;

    localparam int SIZE_DIGITS  = hcbd_pkg::SIZE_DIGITS_DEF;
    localparam int TARGET_ITEMS = 1625;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_X     = 8'h78;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_in_byte    = 8'h00;
    logic       i_body_start = 1'b0;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic [1:0] o_result_kind;

    int fail_count;
    int owed_count;
    int cycle_count = 0;
    int burst_left  = 0;
    int items_sent  = 0;
    bit start_next  = 1'b0;
    int stall_mode  = 0;
    int stall_run   = 0;

    http_chunked_body_decoder #(
        .SIZE_DIGITS(SIZE_DIGITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_body_start (i_body_start),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_result_kind(o_result_kind)
    );

    hcbd_checker #(
        .SIZE_DIGITS(SIZE_DIGITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_body_start (i_body_start),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_byte   (o_out_byte),
        .i_result_kind(o_result_kind),
        .o_fail_count (fail_count),
        .o_pending    (owed_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // End the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Stall the output in stretches: free, light, half and heavy
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(4, 40);
        end
        stall_run--;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= 1'($urandom_range(0, 1));
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Offer one byte and hold it until accepted; open a fresh burst after a random gap
    task automatic send(input logic [7:0] b, input bit counts);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_in_byte    <= b;
        i_body_start <= start_next;
        start_next   = 1'b0;
        do @(posedge i_clk); while (o_in_stall);
        if (counts) begin
            items_sent++;
        end
    endtask

    // Send the low n hex digits of value, most significant first, in random case
    task automatic send_digits(input logic [63:0] value, input int n);
        int         i;
        logic [3:0] nib;
        logic [7:0] c;
        for (i = n - 1; i >= 0; i--) begin
            nib = value[4*i +: 4];
            if (nib < 4'd10) begin
                c = 8'h30 + nib;
            end else begin
                c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + (nib - 4'd10);
            end
            send(c, 1'b1);
        end
    endtask

    task automatic send_crlf();
        send(hcbd_pkg::BYTE_CR, 1'b1);
        send(hcbd_pkg::BYTE_LF, 1'b1);
    endtask

    // One well-formed chunk; cut it short now and then and report that through cut
    task automatic good_chunk(output bit cut);
        int len;
        int min_digits;
        int stop_at;
        int k;
        cut        = 1'b0;
        len        = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
        min_digits = (len < 16) ? 1 : 2;
        send_digits(64'(len), $urandom_range(min_digits, SIZE_DIGITS));
        send_crlf();
        stop_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : len;
        for (k = 0; k < stop_at; k++) begin
            send(8'($urandom_range(0, 255)), 1'b1);
        end
        if (stop_at < len) begin
            cut = 1'b1;
        end else if ($urandom_range(0, 4) != 0) begin
            send_crlf();
        end else begin
            send(8'($urandom_range(0, 255)), 1'b1);
            send(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // One body: mostly well-formed chunks and a terminator, sometimes a broken size line
    task automatic random_body();
        int         pick;
        int         n_chunks;
        int         k;
        int         n;
        bit         cut;
        logic [7:0] b;
        logic [63:0] val;
        start_next = 1'b1;
        pick       = $urandom_range(0, 99);
        n_chunks   = (pick < 80) ? $urandom_range(0, 3) : $urandom_range(0, 1);
        cut        = 1'b0;
        for (k = 0; k < n_chunks && !cut; k++) begin
            good_chunk(cut);
        end
        if (cut) begin
            return;
        end
        val = {$urandom, $urandom};
        if (pick < 80) begin
            // terminate with zero or empty size, then trail a little ignored junk
            send_digits(64'h0, $urandom_range(0, SIZE_DIGITS));
            send_crlf();
            if ($urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++) begin
                    send(8'($urandom_range(0, 255)), 1'b0);
                end
            end
        end else begin
            case ((pick - 80) / 4)
                0: begin
                    // one digit too many
                    send_digits(val, SIZE_DIGITS + 1);
                end
                1: begin
                    // bad character inside the size line
                    send_digits(val, $urandom_range(0, SIZE_DIGITS));
                    case ($urandom_range(0, 3))
                        0:       b = hcbd_pkg::BYTE_LF;
                        1:       b = CH_SPACE;
                        2:       b = CH_SEMI;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                        (b >= 8'h61 && b <= 8'h66) || b == hcbd_pkg::BYTE_CR) begin
                        b = CH_SEMI;
                    end
                    send(b, 1'b1);
                end
                2: begin
                    // CR not followed by LF
                    send_digits(val, $urandom_range(0, SIZE_DIGITS));
                    send(hcbd_pkg::BYTE_CR, 1'b1);
                    b = 8'($urandom_range(0, 255));
                    if (b == hcbd_pkg::BYTE_LF) begin
                        b = hcbd_pkg::BYTE_CR;
                    end
                    send(b, 1'b1);
                end
                3: begin
                    // full-width size, stream truncated inside the payload
                    if ($urandom_range(0, 1) == 0) begin
                        val = '1;
                    end
                    send_digits(val, SIZE_DIGITS);
                    send_crlf();
                    n = $urandom_range(0, 5);
                    for (k = 0; k < n; k++) begin
                        send(8'($urandom_range(0, 255)), 1'b1);
                    end
                end
                default: begin
                    n = $urandom_range(1, 12);
                    for (k = 0; k < n; k++) begin
                        send(8'($urandom_range(0, 255)), 1'b1);
                    end
                end
            endcase
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // body with no start flag: one-byte chunk, odd trailer, empty size line, junk after end
        send_digits(64'h1, 1);
        send_crlf();
        send(8'hFF, 1'b1);
        send(8'h00, 1'b1);
        send(8'hFF, 1'b1);
        send_crlf();
        send(CH_UP_A, 1'b0);

        // maximum digit count, then one digit too many
        start_next = 1'b1;
        send_digits('1, SIZE_DIGITS + 1);

        // chunk extension, bare LF, CR without LF
        start_next = 1'b1;
        send(CH_SEMI, 1'b1);
        start_next = 1'b1;
        send(hcbd_pkg::BYTE_LF, 1'b1);
        start_next = 1'b1;
        send(hcbd_pkg::BYTE_CR, 1'b1);
        send(CH_X, 1'b1);

        // zero size
        start_next = 1'b1;
        send_digits(64'h0, 1);
        send_crlf();

        while (items_sent < TARGET_ITEMS) begin
            random_body();
        end

        // drain every owed result, then watch for strays
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (owed_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
